// ===== rtl/first_fit_heap_allocator_assert.svh =====
// Assertion macros shared by the allocator's RTL modules.
// Each file that checks its own logic includes this header; it needs no other file.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// A condition that must imply another in the same cycle.
`define FFHA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// A condition that must imply another in the next cycle.
`define FFHA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

// ===== rtl/ffha_pkg.sv =====
// Types and constants shared by the first-fit allocator's controller, datapath and top level.
// No dependencies.
`default_nettype none
package ffha_pkg;

    localparam int WORD_BYTES   = 4;
    localparam int WORD_SH      = 2;
    localparam int HEADER_BYTES = 16;
    localparam int HEAP_RESET   = 4096;
    localparam int REQ_W        = 12;
    localparam int OFF_W        = 12;
    localparam int HEAP_W       = 13;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_ZERO    = 2'd2,
        ST_BADFREE = 2'd3
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_CHECK,
        S_A_SPLIT,
        S_A_LINK,
        S_F_CHECK,
        S_F_PREV,
        S_F_NEXT,
        S_F_FIN
    } t_state;

    typedef enum logic [3:0] {
        UOP_NONE,
        UOP_CLEAR,
        UOP_LOAD,
        UOP_A_CHECK,
        UOP_A_SPLIT,
        UOP_A_LINK,
        UOP_F_CHECK,
        UOP_F_PREV,
        UOP_F_NEXT,
        UOP_F_FIN
    } t_uop;

    typedef struct packed {
        t_uop    uop;
        logic    cfg_load;
        logic    finish;
        t_status status;
        logic    give_offset;
    } t_cmd;

    typedef struct packed {
        logic req_zero;
        logic free_bad_in;
        logic a_fit;
        logic a_split;
        logic a_end;
        logic f_bad;
        logic y_nonzero;
        logic z_new_in;
        logic z_in;
        logic clr_last;
    } t_stat;

endpackage
`default_nettype wire

// ===== rtl/ffha_ctrl.sv =====
// Sequencer of the first-fit allocator: walks allocate and free operations step by step.
// Depends on ffha_pkg and the assertion header.
`default_nettype none
`include "first_fit_heap_allocator_assert.svh"
module ffha_ctrl
    import ffha_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_opcode i_opcode,
    input  wire logic    i_cfg_valid,
    input  wire t_stat   i_stat,
    output t_cmd         o_cmd,
    output logic         o_busy,
    output logic         o_cfg_ready
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        o_cmd.uop         = UOP_NONE;
        o_cmd.cfg_load    = 1'b0;
        o_cmd.finish      = 1'b0;
        o_cmd.status      = ST_OK;
        o_cmd.give_offset = 1'b0;
        case (r_state)
            S_CLEAR: begin
                if (i_cfg_valid) begin
                    o_cmd.cfg_load = 1'b1;
                end else begin
                    o_cmd.uop = UOP_CLEAR;
                    if (i_stat.clr_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (i_cfg_valid) begin
                    o_cmd.cfg_load = 1'b1;
                    n_state        = S_CLEAR;
                end else if (i_start) begin
                    if (i_opcode == OP_ALLOC) begin
                        if (i_stat.req_zero) begin
                            o_cmd.finish = 1'b1;
                            o_cmd.status = ST_ZERO;
                        end else begin
                            o_cmd.uop = UOP_LOAD;
                            n_state   = S_A_CHECK;
                        end
                    end else begin
                        if (i_stat.free_bad_in) begin
                            o_cmd.finish = 1'b1;
                            o_cmd.status = ST_BADFREE;
                        end else begin
                            o_cmd.uop = UOP_LOAD;
                            n_state   = S_F_CHECK;
                        end
                    end
                end
            end
            S_A_CHECK: begin
                o_cmd.uop = UOP_A_CHECK;
                if (i_stat.a_fit) begin
                    if (i_stat.a_split) begin
                        n_state = S_A_SPLIT;
                    end else begin
                        o_cmd.finish      = 1'b1;
                        o_cmd.give_offset = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else if (i_stat.a_end) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_NOFIT;
                    n_state      = S_IDLE;
                end
            end
            S_A_SPLIT: begin
                o_cmd.uop = UOP_A_SPLIT;
                if (i_stat.z_in) begin
                    n_state = S_A_LINK;
                end else begin
                    o_cmd.finish      = 1'b1;
                    o_cmd.give_offset = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_A_LINK: begin
                o_cmd.uop         = UOP_A_LINK;
                o_cmd.finish      = 1'b1;
                o_cmd.give_offset = 1'b1;
                n_state           = S_IDLE;
            end
            S_F_CHECK: begin
                o_cmd.uop = UOP_F_CHECK;
                if (i_stat.f_bad) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_BADFREE;
                    n_state      = S_IDLE;
                end else if (i_stat.y_nonzero) begin
                    n_state = S_F_PREV;
                end else if (i_stat.z_new_in) begin
                    n_state = S_F_NEXT;
                end else begin
                    n_state = S_F_FIN;
                end
            end
            S_F_PREV: begin
                o_cmd.uop = UOP_F_PREV;
                n_state   = i_stat.z_in ? S_F_NEXT : S_F_FIN;
            end
            S_F_NEXT: begin
                o_cmd.uop = UOP_F_NEXT;
                n_state   = S_F_FIN;
            end
            S_F_FIN: begin
                o_cmd.uop    = UOP_F_FIN;
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_busy      = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE) || (r_state == S_CLEAR);

    `FFHA_ASSERT_NOW(a_no_finish_in_clear, r_state == S_CLEAR, !o_cmd.finish)
    `FFHA_ASSERT_NEXT(a_load_enters_check, o_cmd.uop == UOP_LOAD,
        r_state == S_A_CHECK || r_state == S_F_CHECK)
    `FFHA_ASSERT_NEXT(a_finish_returns_idle, o_cmd.finish, r_state == S_IDLE)

endmodule
`default_nettype wire

// ===== rtl/ffha_dp.sv =====
// Datapath of the first-fit allocator: chunk header memory, previous-link memory and offsets.
// Depends on ffha_pkg and the assertion header.
`default_nettype none
`include "first_fit_heap_allocator_assert.svh"
module ffha_dp
    import ffha_pkg::*;
#(
    parameter int ARENA_BYTES = 4096
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire t_opcode           i_opcode,
    input  wire logic [REQ_W-1:0]  i_request_bytes,
    input  wire logic [OFF_W-1:0]  i_data_offset_in,
    input  wire logic [HEAP_W-1:0] i_cfg_heap_bytes,
    output t_stat                  o_stat,
    output logic                   o_done,
    output t_status                o_status,
    output logic [OFF_W-1:0]       o_data_offset
);

    localparam int SLOTS = (ARENA_BYTES + WORD_BYTES - 1) / WORD_BYTES;
    localparam int AW    = $clog2(SLOTS);
    localparam int OW    = $clog2(ARENA_BYTES + 1);
    localparam int CW    = ((OW > HEAP_W) ? OW : HEAP_W) + 1;

    typedef struct packed {
        logic          start;
        logic          used;
        logic [OW-1:0] size;
    } t_hdr;

    function automatic logic [AW-1:0] slot_of(input logic [CW-1:0] off);
        slot_of = AW'(off >> WORD_SH);
    endfunction

    function automatic logic [OW-1:0] clamp_end(input logic [HEAP_W-1:0] v);
        logic [CW-1:0] w;
        w = CW'(v);
        if (w > CW'(ARENA_BYTES)) begin
            clamp_end = OW'(ARENA_BYTES);
        end else if (w < CW'(HEADER_BYTES)) begin
            clamp_end = OW'(HEADER_BYTES);
        end else begin
            clamp_end = OW'(w);
        end
    endfunction

    t_hdr          r_hdr_mem [SLOTS];
    logic [OW-1:0] r_prev_mem [SLOTS];
    t_hdr          r_hdr_q;
    logic [OW-1:0] r_prev_q;

    logic [OW-1:0] r_arena_end, n_arena_end;
    logic [AW-1:0] r_clr, n_clr;
    logic [CW-1:0] r_need, n_need;
    logic [OW-1:0] r_x, n_x;
    logic [OW-1:0] r_y, n_y;
    logic [OW-1:0] r_z, n_z;
    logic [OW-1:0] r_cur, n_cur;
    logic          r_merged, n_merged;
    logic          r_out_valid;
    t_status       r_out_status;
    logic [OFF_W-1:0] r_out_off;

    logic [AW-1:0] rd_addr;
    logic          hdr_we, prev_we;
    logic [AW-1:0] hdr_wa, prev_wa;
    t_hdr          hdr_wd;
    logic [OW-1:0] prev_wd;

    logic [CW-1:0] need_c, y_in, hsz, end_c, x_next, z_c, zn_c;

    always_comb begin
        end_c  = CW'(r_arena_end);
        need_c = (CW'(i_request_bytes) + CW'(WORD_BYTES - 1)) & ~CW'(WORD_BYTES - 1);
        y_in   = CW'(i_data_offset_in) - CW'(HEADER_BYTES);
        hsz    = CW'(r_hdr_q.size);
        x_next = CW'(r_x) + CW'(HEADER_BYTES) + hsz;
        z_c    = CW'(r_y) + CW'(HEADER_BYTES) + hsz;
        zn_c   = CW'(r_z) + CW'(HEADER_BYTES) + hsz;

        o_stat.req_zero    = (need_c == '0);
        o_stat.free_bad_in = (CW'(i_data_offset_in) < CW'(HEADER_BYTES))
                             || (y_in[WORD_SH-1:0] != '0) || (y_in >= end_c);
        o_stat.a_fit       = !r_hdr_q.used && (hsz >= r_need);
        o_stat.a_split     = hsz >= (r_need + CW'(HEADER_BYTES + 1));
        o_stat.a_end       = x_next >= end_c;
        o_stat.f_bad       = !r_hdr_q.start || !r_hdr_q.used;
        o_stat.y_nonzero   = (r_y != '0);
        o_stat.z_new_in    = z_c < end_c;
        o_stat.z_in        = CW'(r_z) < end_c;
        o_stat.clr_last    = (CW'(r_clr) == CW'(SLOTS - 1));

        n_arena_end = r_arena_end;
        n_clr       = r_clr;
        n_need      = r_need;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_cur       = r_cur;
        n_merged    = r_merged;
        rd_addr     = '0;
        hdr_we      = 1'b0;
        hdr_wa      = slot_of(CW'(r_y));
        hdr_wd      = '0;
        prev_we     = 1'b0;
        prev_wa     = slot_of(CW'(r_z));
        prev_wd     = r_y;

        if (i_cmd.cfg_load) begin
            n_arena_end = clamp_end(i_cfg_heap_bytes);
            n_clr       = '0;
        end

        case (i_cmd.uop)
            UOP_CLEAR: begin
                hdr_we = 1'b1;
                hdr_wa = r_clr;
                if (r_clr == '0) begin
                    hdr_wd.start = 1'b1;
                    hdr_wd.size  = r_arena_end - OW'(HEADER_BYTES);
                end
                n_clr = r_clr + AW'(1);
            end
            UOP_LOAD: begin
                n_need   = need_c;
                n_x      = '0;
                n_y      = OW'(y_in);
                n_merged = 1'b0;
                rd_addr  = (i_opcode == OP_FREE) ? slot_of(y_in) : '0;
            end
            UOP_A_CHECK: begin
                if (o_stat.a_fit) begin
                    hdr_we       = 1'b1;
                    hdr_wa       = slot_of(CW'(r_x));
                    hdr_wd.start = 1'b1;
                    hdr_wd.used  = 1'b1;
                    hdr_wd.size  = o_stat.a_split ? OW'(r_need) : r_hdr_q.size;
                    n_y   = OW'(CW'(r_x) + CW'(HEADER_BYTES) + r_need);
                    n_cur = OW'(hsz - r_need - CW'(HEADER_BYTES));
                    n_z   = OW'(x_next);
                end else begin
                    n_x     = OW'(x_next);
                    rd_addr = slot_of(x_next);
                end
            end
            UOP_A_SPLIT: begin
                hdr_we       = 1'b1;
                hdr_wd.start = 1'b1;
                hdr_wd.size  = r_cur;
                prev_we      = 1'b1;
                prev_wa      = slot_of(CW'(r_y));
                prev_wd      = r_x;
            end
            UOP_A_LINK: begin
                prev_we = 1'b1;
            end
            UOP_F_CHECK: begin
                n_cur   = r_hdr_q.size;
                n_z     = OW'(z_c);
                n_x     = r_prev_q;
                rd_addr = o_stat.y_nonzero ? slot_of(CW'(r_prev_q)) : slot_of(z_c);
            end
            UOP_F_PREV: begin
                rd_addr = slot_of(CW'(r_z));
                if (!r_hdr_q.used) begin
                    // Fold this chunk into its free predecessor.
                    hdr_we   = 1'b1;
                    n_cur    = OW'(hsz + CW'(r_cur) + CW'(HEADER_BYTES));
                    n_y      = r_x;
                    n_merged = 1'b1;
                end
            end
            UOP_F_NEXT: begin
                if (!r_hdr_q.used) begin
                    hdr_we  = 1'b1;
                    hdr_wa  = slot_of(CW'(r_z));
                    n_cur   = OW'(CW'(r_cur) + hsz + CW'(HEADER_BYTES));
                    prev_we = zn_c < end_c;
                    prev_wa = slot_of(zn_c);
                end else begin
                    prev_we = r_merged;
                end
            end
            UOP_F_FIN: begin
                hdr_we       = 1'b1;
                hdr_wd.start = 1'b1;
                hdr_wd.size  = r_cur;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_hdr_q  <= r_hdr_mem[rd_addr];
        r_prev_q <= r_prev_mem[rd_addr];
        if (hdr_we) begin
            r_hdr_mem[hdr_wa] <= hdr_wd;
        end
        if (prev_we) begin
            r_prev_mem[prev_wa] <= prev_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena_end <= clamp_end(HEAP_W'(HEAP_RESET));
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_merged    <= 1'b0;
        end else begin
            r_arena_end <= n_arena_end;
            r_clr       <= n_clr;
            r_out_valid <= i_cmd.finish;
            r_merged    <= n_merged;
        end
    end

    always_ff @(posedge i_clk) begin
        r_need <= n_need;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_cur  <= n_cur;
        if (i_cmd.finish) begin
            r_out_status <= i_cmd.status;
            r_out_off    <= i_cmd.give_offset
                            ? OFF_W'(CW'(r_x) + CW'(HEADER_BYTES)) : '0;
        end
    end

    assign o_done        = r_out_valid;
    assign o_status      = r_out_status;
    assign o_data_offset = r_out_off;

    `FFHA_ASSERT_NOW(a_end_in_range, 1'b1,
        CW'(r_arena_end) >= CW'(HEADER_BYTES) && CW'(r_arena_end) <= CW'(ARENA_BYTES))
    `FFHA_ASSERT_NOW(a_error_zero_offset, r_out_valid && r_out_status != ST_OK,
        r_out_off == '0)
    `FFHA_ASSERT_NOW(a_offset_aligned, r_out_valid && r_out_status == ST_OK,
        r_out_off[WORD_SH-1:0] == '0)

endmodule
`default_nettype wire

// ===== rtl/first_fit_heap_allocator.sv =====
// Top level of the first-fit heap allocator with coalescing.
// Depends on ffha_pkg, ffha_ctrl and ffha_dp.
//
// Channel    Direction  Handshake                     Payload
// command    in         i_start, o_busy               i_opcode, i_request_bytes, i_data_offset_in
// result     out        o_done (one-cycle strobe)     o_status, o_data_offset
// config     in         i_cfg_valid, o_cfg_ready      i_cfg_heap_bytes
//
// An allocate loads the request and walks the chunk headers, one header per cycle, until one
// fits or the walk ends; a split takes a split step and, if a chunk follows, a link step. A free
// checks the chunk, may merge it with the chunks before and after it, then writes its header.
// Zero-size requests and frees that fail the offset checks finish straight from idle. After
// reset, and after each configuration transfer, a clearing pass rewrites the header memory
// while busy is high. The result is shown for one cycle and cannot be stalled.
`default_nettype none
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int ARENA_BYTES = 4096
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire logic              i_opcode,
    input  wire logic [REQ_W-1:0]  i_request_bytes,
    input  wire logic [OFF_W-1:0]  i_data_offset_in,
    output logic                   o_done,
    output logic [1:0]             o_status,
    output logic [OFF_W-1:0]       o_data_offset,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [HEAP_W-1:0] i_cfg_heap_bytes
);

    // Command and status between the sequencer and the datapath.
    t_cmd    cmd;
    t_stat   stat;
    t_opcode opcode;
    t_status status;

    assign opcode   = t_opcode'(i_opcode);
    assign o_status = status;

    // The sequencer decides each step; the datapath holds the memories and offsets.
    ffha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_opcode    (opcode),
        .i_cfg_valid (i_cfg_valid),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (o_busy),
        .o_cfg_ready (o_cfg_ready)
    );

    ffha_dp #(
        .ARENA_BYTES (ARENA_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_opcode         (opcode),
        .i_request_bytes  (i_request_bytes),
        .i_data_offset_in (i_data_offset_in),
        .i_cfg_heap_bytes (i_cfg_heap_bytes),
        .o_stat           (stat),
        .o_done           (o_done),
        .o_status         (status),
        .o_data_offset    (o_data_offset)
    );

endmodule
`default_nettype wire
